[rtl/muller_polynomial_root_finder_core_assert.svh]
// Assertion macros for the root finder core.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef MULLER_POLYNOMIAL_ROOT_FINDER_CORE_ASSERT_SVH
`define MULLER_POLYNOMIAL_ROOT_FINDER_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MPRF_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MPRF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/mprf_pkg.sv]
package mprf_pkg;

  // Operations of the shared arithmetic unit.
  typedef enum logic [1:0] {
    OP_MUL  = 2'd0,
    OP_DIV  = 2'd1,
    OP_SQRT = 2'd2
  } arith_op_e;

  typedef struct packed {
    logic      start;
    arith_op_e op;
  } arith_req_t;

  typedef struct packed {
    logic done;
    logic divzero;
  } arith_rsp_t;

  // Result status codes.
  typedef enum logic [1:0] {
    STAT_CONV    = 2'd0,
    STAT_LIMIT   = 2'd1,
    STAT_NEGDISC = 2'd2,
    STAT_DIVZERO = 2'd3
  } status_e;

  // Configuration register indexes.
  localparam logic [2:0] CFG_COEFF_FOUR  = 3'd0;
  localparam logic [2:0] CFG_COEFF_THREE = 3'd1;
  localparam logic [2:0] CFG_COEFF_TWO   = 3'd2;
  localparam logic [2:0] CFG_COEFF_ONE   = 3'd3;
  localparam logic [2:0] CFG_COEFF_ZERO  = 3'd4;
  localparam logic [2:0] CFG_TOLERANCE   = 3'd5;
  localparam logic [2:0] CFG_ITER_LIMIT  = 3'd6;

  // Register reset values.
  localparam logic [63:0] RST_COEFF_FOUR  = 64'h0000_1000_0000_0000;
  localparam logic [63:0] RST_COEFF_THREE = 64'hFFFF_D800_0000_0000;
  localparam logic [63:0] RST_COEFF_TWO   = 64'h0000_0500_0000_0000;
  localparam logic [63:0] RST_COEFF_ONE   = 64'h0000_1400_0000_0000;
  localparam logic [63:0] RST_COEFF_ZERO  = 64'h0000_0600_0000_0000;
  localparam logic [62:0] RST_TOLERANCE   = 63'd10995116;
  localparam logic [7:0]  RST_ITER_LIMIT  = 8'd64;

  localparam logic [63:0] SAT_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] SAT_MIN = 64'h8000_0000_0000_0000;

  // Saturating two's complement add.
  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] s;
    s = a + b;
    if (!a[63] && !b[63] && s[63]) return SAT_MAX;
    if (a[63] && b[63] && !s[63]) return SAT_MIN;
    return s;
  endfunction

  // Saturating two's complement subtract.
  function automatic logic [63:0] sat_sub(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] d;
    d = a - b;
    if (!a[63] && b[63] && d[63]) return SAT_MAX;
    if (a[63] && !b[63] && !d[63]) return SAT_MIN;
    return d;
  endfunction

  // Unsigned magnitude of a signed value.
  function automatic logic [63:0] mag(input logic [63:0] a);
    return a[63] ? (64'd0 - a) : a;
  endfunction

  // Signed result from sign, overflow flag and magnitude, with saturation.
  function automatic logic [63:0] from_mag(input logic neg, input logic ovf,
                                           input logic [63:0] m);
    if (neg) begin
      if (ovf || (m[63] && (|m[62:0]))) return SAT_MIN;
      return 64'd0 - m;
    end
    if (ovf || m[63]) return SAT_MAX;
    return m;
  endfunction

endpackage

[rtl/muller_polynomial_root_finder_core.sv]
// Each pass of the iteration is dominated by four 64-step bit-serial divisions and one
// 64-step square root on the single shared arithmetic unit.
// Throughput: one request at a time; busy stays high until the result strobe.
// The result is shown for exactly one cycle and cannot be stalled.
// Reset (asynchronous, active low) returns to idle and restores the register defaults.
module muller_polynomial_root_finder_core import mprf_pkg::*; #(
  parameter int FRAC_BITS   = 40,
  parameter int POLY_DEGREE = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic signed [63:0] guess_first_i,
  input  logic signed [63:0] guess_second_i,
  input  logic signed [63:0] guess_third_i,
  output logic               result_valid_o,
  output logic signed [63:0] root_o,
  output logic        [7:0]  passes_o,
  output logic        [1:0]  status_o,
  input  logic               cfg_we_i,
  input  logic        [2:0]  cfg_idx_i,
  input  logic        [63:0] cfg_data_i
);

  localparam int KW = (POLY_DEGREE > 1) ? $clog2(POLY_DEGREE) : 1;

  typedef enum logic [28:0] {
    ST_IDLE   = 29'd1 << 0,
    ST_P_INIT = 29'd1 << 1,
    ST_P_MUL  = 29'd1 << 2,
    ST_P_ADD  = 29'd1 << 3,
    ST_H1     = 29'd1 << 4,
    ST_H2     = 29'd1 << 5,
    ST_DF1    = 29'd1 << 6,
    ST_D1     = 29'd1 << 7,
    ST_DF2    = 29'd1 << 8,
    ST_D2     = 29'd1 << 9,
    ST_DD     = 29'd1 << 10,
    ST_HS     = 29'd1 << 11,
    ST_A      = 29'd1 << 12,
    ST_AH     = 29'd1 << 13,
    ST_B      = 29'd1 << 14,
    ST_BB     = 29'd1 << 15,
    ST_A2     = 29'd1 << 16,
    ST_A4     = 29'd1 << 17,
    ST_AC     = 29'd1 << 18,
    ST_DISC   = 29'd1 << 19,
    ST_SQRT   = 29'd1 << 20,
    ST_BM     = 29'd1 << 21,
    ST_BP     = 29'd1 << 22,
    ST_RAD    = 29'd1 << 23,
    ST_C2     = 29'd1 << 24,
    ST_Q      = 29'd1 << 25,
    ST_X3     = 29'd1 << 26,
    ST_STEP   = 29'd1 << 27,
    ST_SPARE  = 29'd1 << 28
  } state_e;

  state_e state_q, state_d;
  logic          wait_q, valid_q;
  logic [7:0]    iter_q;
  logic [KW-1:0] k_q;
  logic [1:0]    pt_q;

  logic [63:0] c4_q, c3_q, c2_q, c1_q, c0_q;
  logic [62:0] tol_q;
  logic [7:0]  lim_q;

  logic [63:0] x0_q, x1_q, x2_q, x3_q, f0_q, f1_q, f2_q;
  logic [63:0] h1_q, h2_q, d1_q, d2_q, a_q, b_q, den_q, t_q, u_q, acc_q;
  logic [63:0] root_q;
  logic [7:0]  passes_q;
  status_e     status_q;

  arith_req_t  req;
  arith_rsp_t  rsp;
  logic [63:0] opa, opb, unit_res;
  logic [63:0] alu_res, coef_hi, coef_k, x_sel, wb_val;
  logic        unit_state, wb_en, fin, fin_x3;
  status_e     fin_status;
  logic [7:0]  lim_eff;

  // Shared multiply, divide and square root.
  mprf_arith #(.FRAC_BITS(FRAC_BITS)) u_arith (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req),
    .opa_i   (opa),
    .opb_i   (opb),
    .rsp_o   (rsp),
    .result_o(unit_res)
  );

  // Coefficient of the leading term and of the current Horner step, and the point being evaluated.
  always_comb begin
    case (POLY_DEGREE)
      0:       coef_hi = c0_q;
      1:       coef_hi = c1_q;
      2:       coef_hi = c2_q;
      3:       coef_hi = c3_q;
      4:       coef_hi = c4_q;
      default: coef_hi = '0;
    endcase
    case (int'(k_q))
      0:       coef_k = c0_q;
      1:       coef_k = c1_q;
      2:       coef_k = c2_q;
      3:       coef_k = c3_q;
      4:       coef_k = c4_q;
      default: coef_k = '0;
    endcase
    case (pt_q)
      2'd0:    x_sel = x0_q;
      2'd1:    x_sel = x1_q;
      default: x_sel = x2_q;
    endcase
  end

  assign lim_eff = (lim_q == 8'd0) ? 8'd1 : lim_q;

  // Combinational saturating add, subtract and compare.
  always_comb begin
    case (state_q) inside
      ST_P_ADD: alu_res = sat_add(acc_q, coef_k);
      ST_H1:    alu_res = sat_sub(x1_q, x0_q);
      ST_H2:    alu_res = sat_sub(x2_q, x1_q);
      ST_DF1:   alu_res = sat_sub(f1_q, f0_q);
      ST_DF2:   alu_res = sat_sub(f2_q, f1_q);
      ST_DD:    alu_res = sat_sub(d2_q, d1_q);
      ST_HS:    alu_res = sat_add(h2_q, h1_q);
      ST_B:     alu_res = sat_add(t_q, d2_q);
      ST_A2:    alu_res = sat_add(a_q, a_q);
      ST_A4:    alu_res = sat_add(u_q, u_q);
      ST_DISC:  alu_res = sat_sub(t_q, u_q);
      ST_BM:    alu_res = sat_sub(b_q, den_q);
      ST_BP:    alu_res = sat_add(b_q, den_q);
      ST_RAD:   alu_res = (mag(t_q) < mag(u_q)) ? u_q : t_q;
      ST_C2:    alu_res = sat_add(f2_q, f2_q);
      ST_X3:    alu_res = sat_sub(x2_q, t_q);
      ST_STEP:  alu_res = sat_sub(x3_q, x2_q);
      default:  alu_res = '0;
    endcase
  end

  // Operands and operation for the shared unit.
  always_comb begin
    unit_state = 1'b1;
    req.op     = OP_MUL;
    opa        = t_q;
    opb        = u_q;
    case (state_q) inside
      ST_P_MUL: begin opa = acc_q; opb = x_sel; end
      ST_D1:    begin req.op = OP_DIV; opb = h1_q; end
      ST_D2:    begin req.op = OP_DIV; opb = h2_q; end
      ST_A, ST_Q: req.op = OP_DIV;
      ST_AH:    begin opa = a_q; opb = h2_q; end
      ST_BB:    begin opa = b_q; opb = b_q; end
      ST_AC:    begin opa = u_q; opb = f2_q; end
      ST_SQRT:  req.op = OP_SQRT;
      default:  unit_state = 1'b0;
    endcase
    req.start = unit_state && !wait_q;
  end

  assign wb_en  = unit_state ? (wait_q && rsp.done) : 1'b1;
  assign wb_val = unit_state ? unit_res : alu_res;

  // Sequencer.
  always_comb begin
    state_d    = state_q;
    fin        = 1'b0;
    fin_x3     = 1'b0;
    fin_status = STAT_CONV;
    unique case (state_q)
      ST_IDLE:   if (start) state_d = ST_P_INIT;
      ST_P_INIT: state_d = ST_P_MUL;
      ST_P_MUL:  if (wb_en) state_d = ST_P_ADD;
      ST_P_ADD: begin
        if (k_q != '0) state_d = ST_P_MUL;
        else if (pt_q == 2'd2) state_d = ST_H1;
        else state_d = ST_P_INIT;
      end
      ST_H1:  state_d = ST_H2;
      ST_H2:  state_d = ST_DF1;
      ST_DF1: state_d = ST_D1;
      ST_D1, ST_D2, ST_A, ST_Q: begin
        if (wb_en) begin
          if (rsp.divzero) begin
            fin        = 1'b1;
            fin_status = STAT_DIVZERO;
          end else begin
            unique case (state_q)
              ST_D1:   state_d = ST_DF2;
              ST_D2:   state_d = ST_DD;
              ST_A:    state_d = ST_AH;
              default: state_d = ST_X3;
            endcase
          end
        end
      end
      ST_DF2: state_d = ST_D2;
      ST_DD:  state_d = ST_HS;
      ST_HS:  state_d = ST_A;
      ST_AH:  if (wb_en) state_d = ST_B;
      ST_B:   state_d = ST_BB;
      ST_BB:  if (wb_en) state_d = ST_A2;
      ST_A2:  state_d = ST_A4;
      ST_A4:  state_d = ST_AC;
      ST_AC:  if (wb_en) state_d = ST_DISC;
      ST_DISC: begin
        if (alu_res[63]) begin
          fin        = 1'b1;
          fin_status = STAT_NEGDISC;
        end else begin
          state_d = ST_SQRT;
        end
      end
      ST_SQRT: if (wb_en) state_d = ST_BM;
      ST_BM:   state_d = ST_BP;
      ST_BP:   state_d = ST_RAD;
      ST_RAD:  state_d = ST_C2;
      ST_C2:   state_d = ST_Q;
      ST_X3:   state_d = ST_STEP;
      ST_STEP: begin
        if (mag(alu_res) < {1'b0, tol_q}) begin
          fin    = 1'b1;
          fin_x3 = 1'b1;
        end else if (iter_q >= lim_eff) begin
          fin        = 1'b1;
          fin_x3     = 1'b1;
          fin_status = STAT_LIMIT;
        end else begin
          state_d = ST_P_INIT;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    if (fin) state_d = ST_IDLE;
  end

  // Control registers and configuration.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      wait_q  <= 1'b0;
      valid_q <= 1'b0;
      iter_q  <= 8'd1;
      k_q     <= '0;
      pt_q    <= '0;
      c4_q    <= RST_COEFF_FOUR;
      c3_q    <= RST_COEFF_THREE;
      c2_q    <= RST_COEFF_TWO;
      c1_q    <= RST_COEFF_ONE;
      c0_q    <= RST_COEFF_ZERO;
      tol_q   <= RST_TOLERANCE;
      lim_q   <= RST_ITER_LIMIT;
    end else begin
      state_q <= state_d;
      valid_q <= fin;
      if (req.start) wait_q <= 1'b1;
      else if (rsp.done) wait_q <= 1'b0;
      if (state_q == ST_IDLE && start) begin
        iter_q <= 8'd1;
        pt_q   <= 2'd0;
      end
      if (state_q == ST_P_INIT) k_q <= KW'(POLY_DEGREE - 1);
      if (state_q == ST_P_ADD) begin
        if (k_q != '0) k_q <= k_q - KW'(1);
        else if (pt_q != 2'd2) pt_q <= pt_q + 2'd1;
      end
      if (state_q == ST_STEP && !fin) iter_q <= iter_q + 8'd1;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_COEFF_FOUR:  c4_q  <= cfg_data_i;
          CFG_COEFF_THREE: c3_q  <= cfg_data_i;
          CFG_COEFF_TWO:   c2_q  <= cfg_data_i;
          CFG_COEFF_ONE:   c1_q  <= cfg_data_i;
          CFG_COEFF_ZERO:  c0_q  <= cfg_data_i;
          CFG_TOLERANCE:   tol_q <= cfg_data_i[62:0];
          CFG_ITER_LIMIT:  lim_q <= cfg_data_i[7:0];
          default:         lim_q <= lim_q;
        endcase
      end
    end
  end

  // Working registers of the iteration.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && start) begin
      x0_q <= guess_first_i;
      x1_q <= guess_second_i;
      x2_q <= guess_third_i;
    end
    if (wb_en) begin
      case (state_q) inside
        ST_P_INIT: acc_q <= coef_hi;
        ST_P_MUL: acc_q <= wb_val;
        ST_P_ADD: begin
          acc_q <= wb_val;
          if (k_q == '0) begin
            case (pt_q)
              2'd0:    f0_q <= wb_val;
              2'd1:    f1_q <= wb_val;
              default: f2_q <= wb_val;
            endcase
          end
        end
        ST_H1:  h1_q  <= wb_val;
        ST_H2:  h2_q  <= wb_val;
        ST_D1:  d1_q  <= wb_val;
        ST_D2:  d2_q  <= wb_val;
        ST_A:   a_q   <= wb_val;
        ST_B:   b_q   <= wb_val;
        ST_SQRT: den_q <= wb_val;
        ST_X3:  x3_q  <= wb_val;
        ST_DF1, ST_DF2, ST_DD, ST_AH, ST_BB, ST_DISC, ST_BM, ST_C2, ST_Q: t_q <= wb_val;
        ST_HS, ST_A2, ST_A4, ST_AC, ST_BP, ST_RAD: u_q <= wb_val;
        default: acc_q <= acc_q;
      endcase
    end
    // Slide the three points forward; the function values of the two kept points are reused.
    if (state_q == ST_STEP && !fin) begin
      x0_q <= x1_q;
      x1_q <= x2_q;
      x2_q <= x3_q;
      f0_q <= f1_q;
      f1_q <= f2_q;
    end
    if (fin) begin
      root_q   <= fin_x3 ? x3_q : x2_q;
      passes_q <= iter_q;
      status_q <= fin_status;
    end
  end

  assign busy           = (state_q != ST_IDLE);
  assign result_valid_o = valid_q;
  assign root_o         = root_q;
  assign passes_o       = passes_q;
  assign status_o       = status_q;

`include "muller_polynomial_root_finder_core_assert.svh"

  `MPRF_ASSERT_NEXT(a_start_busy, start && !busy, busy, "accepted request did not raise busy")
  `MPRF_ASSERT_NEXT(a_valid_pulse, result_valid_o, !result_valid_o, "result strobe longer than one cycle")
  `MPRF_ASSERT_IMPLY(a_passes_nz, result_valid_o, passes_o != 8'd0, "result with zero passes")
  `MPRF_ASSERT_IMPLY(a_unit_awaited, rsp.done, wait_q, "unit finished with no operation pending")

endmodule

[rtl/mprf_arith.sv]
// Shared multi-cycle unit: fixed-point multiply, divide and square root.
module mprf_arith import mprf_pkg::*; #(
  parameter int FRAC_BITS = 40
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  arith_req_t  req_i,
  input  logic [63:0] opa_i,
  input  logic [63:0] opb_i,
  output arith_rsp_t  rsp_o,
  output logic [63:0] result_o
);

  typedef enum logic [4:0] {
    U_IDLE = 5'b00001,
    U_MUL  = 5'b00010,
    U_MFIN = 5'b00100,
    U_DIV  = 5'b01000,
    U_SQRT = 5'b10000
  } ustate_e;

  ustate_e      state_q;
  logic [63:0]  ma_q, mb_q, quo_q, res_q;
  logic [127:0] acc_q;
  logic [65:0]  rem_q;
  logic [5:0]   cnt_q;
  logic         neg_q, done_q, dz_q;

  logic [63:0]  ma_in, mb_in, nhi;
  logic [31:0]  a_half, b_half;
  logic [63:0]  pp;
  logic [6:0]   pp_sh;
  logic [64:0]  div_r2;
  logic         div_ge;
  logic [67:0]  sq_r2, sq_trial;
  logic         sq_ge;

  assign ma_in = mag(opa_i);
  assign mb_in = mag(opb_i);
  assign nhi   = ma_in >> (64 - FRAC_BITS);

  // One 32x32 partial product per multiply step.
  assign a_half = cnt_q[1] ? ma_q[63:32] : ma_q[31:0];
  assign b_half = cnt_q[0] ? mb_q[63:32] : mb_q[31:0];
  assign pp     = a_half * b_half;
  always_comb begin
    case (cnt_q[1:0])
      2'd0:    pp_sh = 7'd0;
      2'd3:    pp_sh = 7'd64;
      default: pp_sh = 7'd32;
    endcase
  end

  // Restoring division step: one quotient bit.
  assign div_r2 = {rem_q[63:0], ma_q[63]};
  assign div_ge = div_r2 >= {1'b0, mb_q};

  // Digit-by-digit square root step: one root bit from two radicand bits.
  assign sq_r2    = {rem_q, acc_q[127:126]};
  assign sq_trial = {2'b00, quo_q, 2'b01};
  assign sq_ge    = sq_r2 >= sq_trial;

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= U_IDLE;
      done_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        U_IDLE: begin
          cnt_q <= '0;
          if (req_i.start) begin
            unique case (req_i.op)
              OP_MUL:  state_q <= U_MUL;
              OP_DIV: begin
                if (opb_i == 64'd0 || nhi >= mb_in) done_q <= 1'b1;
                else state_q <= U_DIV;
              end
              OP_SQRT: state_q <= U_SQRT;
              default: done_q <= 1'b1;
            endcase
          end
        end
        U_MUL: begin
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'd3) state_q <= U_MFIN;
        end
        U_MFIN: begin
          done_q  <= 1'b1;
          state_q <= U_IDLE;
        end
        U_DIV, U_SQRT: begin
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'd63) begin
            done_q  <= 1'b1;
            state_q <= U_IDLE;
          end
        end
        default: state_q <= U_IDLE;
      endcase
    end
  end

  // Datapath.
  always_ff @(posedge clk_i) begin
    case (state_q)
      U_IDLE: begin
        if (req_i.start) begin
          neg_q <= opa_i[63] ^ opb_i[63];
          dz_q  <= 1'b0;
          quo_q <= '0;
          case (req_i.op)
            OP_MUL: begin
              ma_q  <= ma_in;
              mb_q  <= mb_in;
              acc_q <= '0;
            end
            OP_DIV: begin
              mb_q  <= mb_in;
              ma_q  <= ma_in << FRAC_BITS;
              rem_q <= {2'b00, nhi};
              if (opb_i == 64'd0) dz_q <= 1'b1;
              else if (nhi >= mb_in) res_q <= from_mag(opa_i[63] ^ opb_i[63], 1'b1, 64'd0);
            end
            OP_SQRT: begin
              acc_q <= {64'd0, opa_i} << FRAC_BITS;
              rem_q <= '0;
            end
            default: res_q <= '0;
          endcase
        end
      end
      U_MUL: acc_q <= acc_q + ({64'd0, pp} << pp_sh);
      U_MFIN: res_q <= from_mag(neg_q, |acc_q[127:64+FRAC_BITS],
                                acc_q[63+FRAC_BITS:FRAC_BITS]);
      U_DIV: begin
        ma_q  <= ma_q << 1;
        quo_q <= {quo_q[62:0], div_ge};
        rem_q <= div_ge ? {2'b00, 64'(div_r2 - {1'b0, mb_q})} : {2'b00, div_r2[63:0]};
        if (cnt_q == 6'd63) res_q <= from_mag(neg_q, 1'b0, {quo_q[62:0], div_ge});
      end
      U_SQRT: begin
        acc_q <= acc_q << 2;
        quo_q <= {quo_q[62:0], sq_ge};
        rem_q <= sq_ge ? 66'(sq_r2 - sq_trial) : sq_r2[65:0];
        if (cnt_q == 6'd63) res_q <= {quo_q[62:0], sq_ge};
      end
      default: res_q <= res_q;
    endcase
  end

  assign rsp_o.done    = done_q;
  assign rsp_o.divzero = dz_q;
  assign result_o      = res_q;

endmodule

[verif/tb_top.sv]
module tb_top;
  import mprf_pkg::*;

  localparam int FRAC = 40;
  localparam longint unsigned CYCLE_LIMIT = 64'd40_000_000;

  localparam logic [63:0] Q_ONE      = 64'h0000_0100_0000_0000;
  localparam logic [63:0] Q_TWO      = 64'h0000_0200_0000_0000;
  localparam logic [63:0] Q_THREE    = 64'h0000_0300_0000_0000;
  localparam logic [63:0] Q_HALF     = 64'h0000_0080_0000_0000;
  localparam logic [63:0] Q_ONE_HALF = 64'h0000_0180_0000_0000;
  localparam logic [63:0] Q_M_ONE    = 64'hFFFF_FF00_0000_0000;
  localparam logic [63:0] Q_M_TWO    = 64'hFFFF_FE00_0000_0000;
  localparam logic [63:0] TOL_MAX    = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef struct {
    logic [63:0] root;
    logic [7:0]  passes;
    status_e     status;
  } outcome_t;

  typedef enum logic [1:0] {
    ROW_ITEM,
    ROW_TYPED,
    ROW_CFG
  } row_kind_e;

  typedef struct {
    row_kind_e   kind;
    logic [2:0]  idx;
    logic [63:0] g0;
    logic [63:0] g1;
    logic [63:0] g2;
    logic [63:0] root;
    logic [7:0]  passes;
    status_e     status;
  } row_t;

  logic               clk_i;
  logic               rst_ni;
  logic               start;
  logic               busy;
  logic        [63:0] guess_first;
  logic        [63:0] guess_second;
  logic        [63:0] guess_third;
  logic               result_valid;
  logic signed [63:0] root;
  logic        [7:0]  passes;
  logic        [1:0]  status;
  logic               cfg_we;
  logic        [2:0]  cfg_idx;
  logic        [63:0] cfg_data;

  // Local copy of the configuration registers, coefficients indexed by degree.
  logic [63:0] poly_coef [0:4];
  logic [62:0] stop_tol;
  logic [7:0]  pass_limit;

  outcome_t    roots_due [$];
  int          err_count;
  longint unsigned cycle_count;

  muller_polynomial_root_finder_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .guess_first_i (guess_first),
    .guess_second_i(guess_second),
    .guess_third_i (guess_third),
    .result_valid_o(result_valid),
    .root_o        (root),
    .passes_o      (passes),
    .status_o      (status),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // Saturating fixed point primitives.
  function automatic logic [63:0] clip_add(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] s;
    s = a + b;
    if (!a[63] && !b[63] && s[63]) return SAT_MAX;
    if (a[63] && b[63] && !s[63]) return SAT_MIN;
    return s;
  endfunction

  function automatic logic [63:0] clip_sub(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] d;
    d = a - b;
    if (!a[63] && b[63] && d[63]) return SAT_MAX;
    if (a[63] && !b[63] && !d[63]) return SAT_MIN;
    return d;
  endfunction

  function automatic logic [63:0] absval(input logic [63:0] a);
    return a[63] ? -a : a;
  endfunction

  function automatic logic [63:0] signed_from(input logic neg, input logic ovf,
                                              input logic [63:0] m);
    if (neg) begin
      if (ovf || m > 64'h8000_0000_0000_0000) return SAT_MIN;
      return -m;
    end
    if (ovf || m[63]) return SAT_MAX;
    return m;
  endfunction

  function automatic logic [63:0] fx_mul(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, absval(a)} * {64'd0, absval(b)};
    p = p >> FRAC;
    return signed_from(a[63] ^ b[63], |p[127:64], p[63:0]);
  endfunction

  // Returns 0 on a zero divisor.
  function automatic bit fx_div(input logic [63:0] a, input logic [63:0] b,
                                output logic [63:0] q);
    logic [63:0]  ma;
    logic [63:0]  mb;
    logic [127:0] quo;
    q = '0;
    if (b == 64'd0) return 1'b0;
    ma = absval(a);
    mb = absval(b);
    if ((ma >> (64 - FRAC)) >= mb) begin
      q = signed_from(a[63] ^ b[63], 1'b1, 64'd0);
    end else begin
      quo = ({64'd0, ma} << FRAC) / {64'd0, mb};
      q = signed_from(a[63] ^ b[63], 1'b0, quo[63:0]);
    end
    return 1'b1;
  endfunction

  function automatic logic [63:0] fx_sqrt(input logic [63:0] v);
    logic [127:0] n;
    logic [63:0]  res;
    logic [63:0]  c;
    n = {64'd0, v} << FRAC;
    res = '0;
    for (int k = 62; k >= 0; k--) begin
      c = res | (64'd1 << k);
      if ({64'd0, c} * {64'd0, c} <= n) res = c;
    end
    return res;
  endfunction

  function automatic logic [63:0] eval_poly(input logic [63:0] x);
    logic [63:0] acc;
    acc = poly_coef[4];
    for (int k = 3; k >= 0; k--) acc = clip_add(fx_mul(acc, x), poly_coef[k]);
    return acc;
  endfunction

  // Runs the whole iteration for one request under the current registers.
  function automatic outcome_t find_root(input logic [63:0] p0, input logic [63:0] p1,
                                         input logic [63:0] p2);
    outcome_t    res;
    logic [63:0] x0, x1, x2, x3, f0, f1, f2;
    logic [63:0] h1, h2, d1, d2, a, b, c, t, disc, den, rad;
    int          lim;
    int          it;
    bit          done;
    x0 = p0;
    x1 = p1;
    x2 = p2;
    lim = (pass_limit == 8'd0) ? 1 : int'(pass_limit);
    it = 0;
    done = 0;
    res.status = STAT_LIMIT;
    while (!done) begin
      it++;
      f0 = eval_poly(x0);
      f1 = eval_poly(x1);
      f2 = eval_poly(x2);
      h1 = clip_sub(x1, x0);
      h2 = clip_sub(x2, x1);
      x3 = x2;
      done = 1;
      if (!fx_div(clip_sub(f1, f0), h1, d1) || !fx_div(clip_sub(f2, f1), h2, d2) ||
          !fx_div(clip_sub(d2, d1), clip_add(h2, h1), a)) begin
        res.status = STAT_DIVZERO;
      end else begin
        b = clip_add(fx_mul(a, h2), d2);
        c = f2;
        t = clip_add(a, a);
        t = clip_add(t, t);
        disc = clip_sub(fx_mul(b, b), fx_mul(t, c));
        if (disc[63]) begin
          res.status = STAT_NEGDISC;
        end else begin
          den = fx_sqrt(disc);
          if (absval(clip_sub(b, den)) < absval(clip_add(b, den))) rad = clip_add(b, den);
          else rad = clip_sub(b, den);
          if (!fx_div(clip_add(c, c), rad, t)) begin
            res.status = STAT_DIVZERO;
          end else begin
            x3 = clip_sub(x2, t);
            if (absval(clip_sub(x3, x2)) < {1'b0, stop_tol}) begin
              res.status = STAT_CONV;
            end else if (it >= lim) begin
              res.status = STAT_LIMIT;
            end else begin
              done = 0;
              x0 = x1;
              x1 = x2;
              x2 = x3;
            end
          end
        end
      end
    end
    res.root = x3;
    res.passes = it[7:0];
    return res;
  endfunction

  // Directed stimulus: special cases at reset settings, then hand-picked polynomials.
  row_t plan_rows [0:25] = '{
    '{ROW_TYPED, 3'd0, 64'd0, 64'd0, 64'd0, 64'd0, 8'd1, STAT_DIVZERO},
    '{ROW_TYPED, 3'd0, SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX, 8'd1, STAT_DIVZERO},
    '{ROW_TYPED, 3'd0, SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN, 8'd1, STAT_DIVZERO},
    '{ROW_TYPED, 3'd0, Q_ONE, Q_ONE, Q_TWO, Q_TWO, 8'd1, STAT_DIVZERO},
    '{ROW_TYPED, 3'd0, 64'd0, Q_ONE, Q_ONE, Q_ONE, 8'd1, STAT_DIVZERO},
    '{ROW_TYPED, 3'd0, Q_ONE, Q_M_ONE, Q_ONE, Q_ONE, 8'd1, STAT_DIVZERO},
    '{ROW_ITEM, 3'd0, Q_M_ONE, 64'd0, Q_ONE, 64'd0, 8'd0, STAT_CONV},
    '{ROW_ITEM, 3'd0, 64'd0, Q_HALF, Q_ONE, 64'd0, 8'd0, STAT_CONV},
    '{ROW_ITEM, 3'd0, Q_TWO, Q_THREE, Q_ONE_HALF, 64'd0, 8'd0, STAT_CONV},
    '{ROW_ITEM, 3'd0, SAT_MIN, 64'd0, SAT_MAX, 64'd0, 8'd0, STAT_CONV},
    '{ROW_ITEM, 3'd0, SAT_MAX, 64'd0, SAT_MIN, 64'd0, 8'd0, STAT_CONV},
    '{ROW_ITEM, 3'd0, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
      64'h0F0F_0F0F_0F0F_0F0F, 64'd0, 8'd0, STAT_CONV},
    // x^2 + 1 with a zero pass limit
    '{ROW_CFG, CFG_COEFF_FOUR, 64'd0, 64'd0, 64'd0, 64'd0, 8'd0, STAT_CONV},
    '{ROW_CFG, CFG_COEFF_THREE, 64'd0, 64'd0, 64'd0, 64'd0, 8'd0, STAT_CONV},
    '{ROW_CFG, CFG_COEFF_TWO, Q_ONE, 64'd0, 64'd0, 64'd0, 8'd0, STAT_CONV},
    '{ROW_CFG, CFG_COEFF_ONE, 64'd0, 64'd0, 64'd0, 64'd0, 8'd0, STAT_CONV},
    '{ROW_CFG, CFG_COEFF_ZERO, Q_ONE, 64'd0, 64'd0, 64'd0, 8'd0, STAT_CONV},
    '{ROW_CFG, CFG_ITER_LIMIT, 64'd0, 64'd0, 64'd0, 64'd0, 8'd0, STAT_CONV},
    '{ROW_TYPED, 3'd0, Q_M_ONE, 64'd0, Q_ONE, Q_ONE, 8'd1, STAT_NEGDISC},
    '{ROW_ITEM, 3'd0, Q_ONE, Q_TWO, Q_THREE, 64'd0, 8'd0, STAT_CONV},
    // x^2 - 2: one pass only, then a huge tolerance, then no tolerance and 255 passes
    '{ROW_CFG, CFG_COEFF_ZERO, Q_M_TWO, 64'd0, 64'd0, 64'd0, 8'd0, STAT_CONV},
    '{ROW_ITEM, 3'd0, Q_ONE, Q_ONE_HALF, Q_TWO, 64'd0, 8'd0, STAT_CONV},
    '{ROW_CFG, CFG_TOLERANCE, TOL_MAX, 64'd0, 64'd0, 64'd0, 8'd0, STAT_CONV},
    '{ROW_ITEM, 3'd0, Q_ONE, Q_ONE_HALF, Q_TWO, 64'd0, 8'd0, STAT_CONV},
    '{ROW_CFG, CFG_TOLERANCE, 64'd0, 64'd0, 64'd0, 64'd0, 8'd0, STAT_CONV},
    '{ROW_CFG, CFG_ITER_LIMIT, 64'd255, 64'd0, 64'd0, 64'd0, 8'd0, STAT_CONV}
  };

  // Writes one register at the next edge; the caller lowers the enable.
  task automatic write_reg(input logic [2:0] idx, input logic [63:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    @(posedge clk_i);
    case (idx)
      CFG_COEFF_FOUR:  poly_coef[4] = data;
      CFG_COEFF_THREE: poly_coef[3] = data;
      CFG_COEFF_TWO:   poly_coef[2] = data;
      CFG_COEFF_ONE:   poly_coef[1] = data;
      CFG_COEFF_ZERO:  poly_coef[0] = data;
      CFG_TOLERANCE:   stop_tol = data[62:0];
      CFG_ITER_LIMIT:  pass_limit = data[7:0];
      default: ;
    endcase
  endtask

  // Presents a request and holds it until accepted; queues its outcome.
  task automatic send_guesses(input logic [63:0] g0, input logic [63:0] g1,
                              input logic [63:0] g2, input bit typed,
                              input outcome_t typed_out);
    start <= 1'b1;
    guess_first <= g0;
    guess_second <= g1;
    guess_third <= g2;
    do @(posedge clk_i); while (busy);
    if (typed) roots_due.push_back(typed_out);
    else roots_due.push_back(find_root(g0, g1, g2));
  endtask

  task automatic sender_gap();
    int r;
    int n;
    r = $urandom_range(0, 9);
    n = (r < 6) ? 0 : (r < 9) ? $urandom_range(1, 4) : $urandom_range(10, 60);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // Lets every pending request finish before the registers change.
  task automatic drain();
    start <= 1'b0;
    while (roots_due.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] rand_small(input int shift);
    logic [63:0] v;
    v = rand64() >> shift;
    return $urandom_range(0, 1) ? -v : v;
  endfunction

  function automatic logic [63:0] rand_coef();
    case ($urandom_range(0, 7))
      0: return rand64();
      1: return SAT_MIN;
      2: return SAT_MAX;
      3: return 64'd0;
      default: return rand_small($urandom_range(20, 28));
    endcase
  endfunction

  // Result checker: compares each strobe with the oldest queued outcome.
  always @(posedge clk_i) begin
    outcome_t want;
    if (rst_ni && result_valid) begin
      if (roots_due.size() == 0) begin
        $display("%0t unexpected result root %h passes %0d status %0d",
                 $time, root, passes, status);
        err_count++;
      end else begin
        want = roots_due.pop_front();
        if (root !== want.root || passes !== want.passes || status !== want.status) begin
          $display("%0t mismatch: expected root %h passes %0d status %0d, got root %h passes %0d status %0d",
                   $time, want.root, want.passes, want.status, root, passes, status);
          err_count++;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL muller_polynomial_root_finder_core");
      $finish;
    end
  end

  initial begin
    outcome_t typed_out;
    row_t     row;
    int       items;
    int       mode;
    logic [63:0] g0, g1, g2, step;
    err_count = 0;
    cycle_count = 0;
    rst_ni = 1'b0;
    start = 1'b0;
    guess_first = '0;
    guess_second = '0;
    guess_third = '0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    poly_coef[4] = RST_COEFF_FOUR;
    poly_coef[3] = RST_COEFF_THREE;
    poly_coef[2] = RST_COEFF_TWO;
    poly_coef[1] = RST_COEFF_ONE;
    poly_coef[0] = RST_COEFF_ZERO;
    stop_tol = RST_TOLERANCE;
    pass_limit = RST_ITER_LIMIT;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table.
    for (int i = 0; i < $size(plan_rows); i++) begin
      row = plan_rows[i];
      if (row.kind == ROW_CFG) begin
        if (i == 0 || plan_rows[i-1].kind != ROW_CFG) drain();
        write_reg(row.idx, row.g0);
        if (i == $size(plan_rows) - 1 || plan_rows[i+1].kind != ROW_CFG) cfg_we <= 1'b0;
      end else begin
        typed_out.root = row.root;
        typed_out.passes = row.passes;
        typed_out.status = row.status;
        send_guesses(row.g0, row.g1, row.g2, row.kind == ROW_TYPED, typed_out);
        sender_gap();
      end
    end
    // Slow setting: only a single request.
    send_guesses(Q_ONE, Q_ONE_HALF, Q_TWO, 1'b0, typed_out);

    // Random phases, each under a fresh register setting.
    for (int ph = 0; ph < 13; ph++) begin
      drain();
      write_reg(CFG_COEFF_FOUR, rand_coef());
      write_reg(CFG_COEFF_THREE, rand_coef());
      write_reg(CFG_COEFF_TWO, rand_coef());
      write_reg(CFG_COEFF_ONE, rand_coef());
      write_reg(CFG_COEFF_ZERO, rand_coef());
      case ($urandom_range(0, 5))
        0: write_reg(CFG_TOLERANCE, 64'd0);
        1: write_reg(CFG_TOLERANCE, TOL_MAX);
        2: write_reg(CFG_TOLERANCE, rand64());
        default: write_reg(CFG_TOLERANCE, 64'($urandom_range(1, 32'h4000_0000)));
      endcase
      mode = $urandom_range(0, 9);
      if (ph == 5 || mode == 0) begin
        write_reg(CFG_ITER_LIMIT, {56'd0, 8'($urandom_range(64, 255))} | 64'hFF00);
        items = 2;
      end else begin
        write_reg(CFG_ITER_LIMIT, (mode == 1) ? 64'd0 : 64'($urandom_range(1, 12)));
        items = 12;
      end
      cfg_we <= 1'b0;
      for (int n = 0; n < items; n++) begin
        if ($urandom_range(0, 9) < 7) begin
          // Three nearby guesses give the iteration a real chance to run.
          g0 = rand_small($urandom_range(20, 24));
          step = rand_small($urandom_range(24, 30));
          g1 = clip_add(g0, step);
          g2 = clip_add(clip_add(g1, step), rand_small(30));
        end else begin
          g0 = rand64();
          g1 = $urandom_range(0, 3) == 0 ? g0 : rand64();
          g2 = rand64();
        end
        send_guesses(g0, g1, g2, 1'b0, typed_out);
        if (n == items / 2) drain();
        else sender_gap();
      end
    end

    drain();
    repeat (20) @(posedge clk_i);
    if (err_count == 0) $display("PASS muller_polynomial_root_finder_core");
    else $display("FAIL muller_polynomial_root_finder_core");
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl
rtl/mprf_pkg.sv
rtl/mprf_arith.sv
rtl/muller_polynomial_root_finder_core.sv
verif/tb_top.sv
